// ----- rtl/segx_pkg.sv -----
package segx_pkg;

	localparam int FRONT_STAGES = 6;
	localparam int BACK_STAGES = 2;

	typedef struct packed {
		logic hit;
		logic use_pt;
		logic par;
		logic neg_x;
		logic neg_y;
	} flags_t;

	localparam int FLAGS_BITS = $bits(flags_t);

endpackage

// ----- rtl/segx_ctrl.sv -----
module segx_ctrl #(
	parameter int NS = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [NS-1:0] en
);

	logic [NS-1:0] v_q;

	// a stage advances when it is empty or the next stage advances
	assign en[NS-1] = !v_q[NS-1] || !out_stall;

	for (genvar k = 0; k < NS - 1; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign in_stall = !en[0];
	assign out_valid = v_q[NS-1];

endmodule

// ----- rtl/segx_front.sv -----
module segx_front #(
	parameter int CB = 32,
	localparam int DW = CB + 1,
	localparam int PW = 2 * DW,
	localparam int CW = PW + 1,
	localparam int NW = CW + CB,
	localparam int H = CB / 2
) (
	input  logic                                 clk,
	input  logic [segx_pkg::FRONT_STAGES-1:0]    en,
	input  logic signed [CB-1:0]                 first_start_x,
	input  logic signed [CB-1:0]                 first_start_y,
	input  logic signed [CB-1:0]                 first_end_x,
	input  logic signed [CB-1:0]                 first_end_y,
	input  logic signed [CB-1:0]                 second_start_x,
	input  logic signed [CB-1:0]                 second_start_y,
	input  logic signed [CB-1:0]                 second_end_x,
	input  logic signed [CB-1:0]                 second_end_y,
	output segx_pkg::flags_t                     flags,
	output logic signed [CB-1:0]                 ptx,
	output logic signed [CB-1:0]                 pty,
	output logic signed [CB-1:0]                 s1x,
	output logic signed [CB-1:0]                 s1y,
	output logic [CW-1:0]                        cm,
	output logic [NW-1:0]                        nx,
	output logic [NW-1:0]                        ny
);

	function automatic logic signed [DW-1:0] sx(input logic signed [CB-1:0] a);
		return {a[CB-1], a};
	endfunction

	function automatic logic signed [CW-1:0] wx_ext(input logic signed [DW-1:0] a);
		return {{(CW-DW){a[DW-1]}}, a};
	endfunction

	function automatic logic in_unit(input logic signed [CW-1:0] num,
			input logic signed [CW-1:0] den);
		logic r;
		if (den == '0) begin
			r = 1'b0;
		end else if (num == '0) begin
			r = 1'b1;
		end else if (num[CW-1] != den[CW-1]) begin
			r = 1'b0;
		end else if (!den[CW-1]) begin
			r = (num <= den);
		end else begin
			r = (num >= den);
		end
		return r;
	endfunction

	function automatic logic between(input logic signed [CB-1:0] p,
			input logic signed [CB-1:0] a, input logic signed [CB-1:0] b);
		logic r;
		if (a <= b) begin
			r = (a <= p) && (p <= b);
		end else begin
			r = (b <= p) && (p <= a);
		end
		return r;
	endfunction

	// stage 1
	logic signed [DW-1:0] v1x_s1, v1y_s1, v2x_s1, v2y_s1, wx_s1, wy_s1, ux_s1, uy_s1;
	logic signed [CB-1:0] s1x_s1, s1y_s1, s2x_s1, s2y_s1, e2x_s1, e2y_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			v1x_s1 <= sx(first_end_x) - sx(first_start_x);
			v1y_s1 <= sx(first_end_y) - sx(first_start_y);
			v2x_s1 <= sx(second_end_x) - sx(second_start_x);
			v2y_s1 <= sx(second_end_y) - sx(second_start_y);
			wx_s1 <= sx(second_start_x) - sx(first_start_x);
			wy_s1 <= sx(second_start_y) - sx(first_start_y);
			ux_s1 <= sx(second_end_x) - sx(first_start_x);
			uy_s1 <= sx(second_end_y) - sx(first_start_y);
			s1x_s1 <= first_start_x;
			s1y_s1 <= first_start_y;
			s2x_s1 <= second_start_x;
			s2y_s1 <= second_start_y;
			e2x_s1 <= second_end_x;
			e2y_s1 <= second_end_y;
		end
	end

	// stage 2
	logic signed [PW-1:0] pc1_s2, pc2_s2, pd1_s2, pd2_s2, pe1_s2, pe2_s2;
	logic signed [DW-1:0] v1x_s2, v1y_s2, wx_s2, wy_s2, ux_s2, uy_s2;
	logic signed [CB-1:0] s1x_s2, s1y_s2, s2x_s2, s2y_s2, e2x_s2, e2y_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pc1_s2 <= v1x_s1 * v2y_s1;
			pc2_s2 <= v1y_s1 * v2x_s1;
			pd1_s2 <= wx_s1 * v2y_s1;
			pd2_s2 <= wy_s1 * v2x_s1;
			pe1_s2 <= wx_s1 * v1y_s1;
			pe2_s2 <= wy_s1 * v1x_s1;
			v1x_s2 <= v1x_s1;
			v1y_s2 <= v1y_s1;
			wx_s2 <= wx_s1;
			wy_s2 <= wy_s1;
			ux_s2 <= ux_s1;
			uy_s2 <= uy_s1;
			s1x_s2 <= s1x_s1;
			s1y_s2 <= s1y_s1;
			s2x_s2 <= s2x_s1;
			s2y_s2 <= s2y_s1;
			e2x_s2 <= e2x_s1;
			e2y_s2 <= e2y_s1;
		end
	end

	// stage 3
	logic signed [CW-1:0] c_s3, d_s3, e_s3;
	logic signed [DW-1:0] v1x_s3, v1y_s3, wx_s3, wy_s3, ux_s3, uy_s3;
	logic signed [CB-1:0] s1x_s3, s1y_s3, s2x_s3, s2y_s3, e2x_s3, e2y_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			c_s3 <= {pc1_s2[PW-1], pc1_s2} - {pc2_s2[PW-1], pc2_s2};
			d_s3 <= {pd1_s2[PW-1], pd1_s2} - {pd2_s2[PW-1], pd2_s2};
			e_s3 <= {pe1_s2[PW-1], pe1_s2} - {pe2_s2[PW-1], pe2_s2};
			v1x_s3 <= v1x_s2;
			v1y_s3 <= v1y_s2;
			wx_s3 <= wx_s2;
			wy_s3 <= wy_s2;
			ux_s3 <= ux_s2;
			uy_s3 <= uy_s2;
			s1x_s3 <= s1x_s2;
			s1y_s3 <= s1y_s2;
			s2x_s3 <= s2x_s2;
			s2y_s3 <= s2y_s2;
			e2x_s3 <= e2x_s2;
			e2y_s3 <= e2y_s2;
		end
	end

	// stage 4: decide
	segx_pkg::flags_t     fl;
	logic signed [CB-1:0] pt_x, pt_y;
	logic                 on_s2, on_e2;

	always_comb begin
		fl = '0;
		pt_x = s2x_s3;
		pt_y = s2y_s3;
		if (v1x_s3 != '0) begin
			on_s2 = in_unit(wx_ext(wx_s3), wx_ext(v1x_s3));
			on_e2 = in_unit(wx_ext(ux_s3), wx_ext(v1x_s3));
		end else begin
			on_s2 = in_unit(wx_ext(wy_s3), wx_ext(v1y_s3));
			on_e2 = in_unit(wx_ext(uy_s3), wx_ext(v1y_s3));
		end
		fl.neg_x = d_s3[CW-1] ^ c_s3[CW-1] ^ v1x_s3[DW-1];
		fl.neg_y = d_s3[CW-1] ^ c_s3[CW-1] ^ v1y_s3[DW-1];
		if (c_s3 == '0) begin
			fl.par = 1'b1;
			fl.use_pt = 1'b1;
			if (d_s3 != '0) begin
				fl.hit = 1'b0;
			end else if (v1x_s3 == '0 && v1y_s3 == '0) begin
				fl.hit = between(s1x_s3, s2x_s3, e2x_s3) && between(s1y_s3, s2y_s3, e2y_s3);
				pt_x = s1x_s3;
				pt_y = s1y_s3;
			end else if (on_s2) begin
				fl.hit = 1'b1;
			end else if (on_e2) begin
				fl.hit = 1'b1;
				pt_x = e2x_s3;
				pt_y = e2y_s3;
			end
		end else begin
			fl.hit = in_unit(d_s3, c_s3) && in_unit(e_s3, c_s3);
		end
	end

	segx_pkg::flags_t     fl_s4;
	logic signed [CB-1:0] ptx_s4, pty_s4, s1x_s4, s1y_s4;
	logic [CW-1:0]        cm_s4, dm_s4;
	logic [CB-1:0]        vmx_s4, vmy_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			fl_s4 <= fl;
			ptx_s4 <= pt_x;
			pty_s4 <= pt_y;
			s1x_s4 <= s1x_s3;
			s1y_s4 <= s1y_s3;
			cm_s4 <= c_s3[CW-1] ? -c_s3 : c_s3;
			dm_s4 <= d_s3[CW-1] ? -d_s3 : d_s3;
			vmx_s4 <= CB'(v1x_s3[DW-1] ? -v1x_s3 : v1x_s3);
			vmy_s4 <= CB'(v1y_s3[DW-1] ? -v1y_s3 : v1y_s3);
		end
	end

	// stage 5: partial products
	segx_pkg::flags_t     fl_s5;
	logic signed [CB-1:0] ptx_s5, pty_s5, s1x_s5, s1y_s5;
	logic [CW-1:0]        cm_s5;
	logic [CW+H-1:0]      plx_s5, ply_s5;
	logic [CW+CB-H-1:0]   phx_s5, phy_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			fl_s5 <= fl_s4;
			ptx_s5 <= ptx_s4;
			pty_s5 <= pty_s4;
			s1x_s5 <= s1x_s4;
			s1y_s5 <= s1y_s4;
			cm_s5 <= cm_s4;
			plx_s5 <= dm_s4 * vmx_s4[H-1:0];
			ply_s5 <= dm_s4 * vmy_s4[H-1:0];
			phx_s5 <= dm_s4 * vmx_s4[CB-1:H];
			phy_s5 <= dm_s4 * vmy_s4[CB-1:H];
		end
	end

	// stage 6: full product
	always_ff @(posedge clk) begin
		if (en[5]) begin
			flags <= fl_s5;
			ptx <= ptx_s5;
			pty <= pty_s5;
			s1x <= s1x_s5;
			s1y <= s1y_s5;
			cm <= cm_s5;
			nx <= NW'(plx_s5) + (NW'(phx_s5) << H);
			ny <= NW'(ply_s5) + (NW'(phy_s5) << H);
		end
	end

endmodule

// ----- rtl/segx_div.sv -----
module segx_div #(
	parameter int CB = 32,
	parameter int CW = 67,
	parameter int NW = 99,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic [CB-1:0] en,
	input  logic [CW-1:0] cm_in,
	input  logic [NW-1:0] nx_in,
	input  logic [NW-1:0] ny_in,
	input  logic [SW-1:0] side_in,
	output logic [CB-1:0] qx,
	output logic [CB-1:0] qy,
	output logic [SW-1:0] side_out
);

	logic [CW-1:0] cm_s [0:CB];
	logic [NW-1:0] rx_s [0:CB];
	logic [NW-1:0] ry_s [0:CB];
	logic [CB-1:0] qx_s [0:CB];
	logic [CB-1:0] qy_s [0:CB];
	logic [SW-1:0] sd_s [0:CB];

	assign cm_s[0] = cm_in;
	assign rx_s[0] = nx_in;
	assign ry_s[0] = ny_in;
	assign qx_s[0] = '0;
	assign qy_s[0] = '0;
	assign sd_s[0] = side_in;

	for (genvar i = 0; i < CB; i++) begin : g_stg
		localparam int B = CB - 1 - i;
		logic [NW-1:0] dvs;
		logic          gex, gey;
		logic [CB-1:0] nqx, nqy;

		always_comb begin
			dvs = NW'(cm_s[i]) << B;
			gex = rx_s[i] >= dvs;
			gey = ry_s[i] >= dvs;
			nqx = qx_s[i];
			nqy = qy_s[i];
			nqx[B] = gex;
			nqy[B] = gey;
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				cm_s[i+1] <= cm_s[i];
				rx_s[i+1] <= gex ? rx_s[i] - dvs : rx_s[i];
				ry_s[i+1] <= gey ? ry_s[i] - dvs : ry_s[i];
				qx_s[i+1] <= nqx;
				qy_s[i+1] <= nqy;
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign qx = qx_s[CB];
	assign qy = qy_s[CB];
	assign side_out = sd_s[CB];

endmodule

// ----- rtl/segment_intersection_2d.sv -----
// Words pass through the front, quotient and back stages to the result word.
// Throughput: one word per cycle; each stage holds only when the stage after it is full
// and stalled, so bubbles are squeezed out.
// Latency is set by the bit-per-stage quotient pipeline for the intersection point.
// Reset clears only the stage valid bits; no result is pending after reset.
module segment_intersection_2d #(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] first_start_x,
	input  logic signed [COORD_BITS-1:0] first_start_y,
	input  logic signed [COORD_BITS-1:0] first_end_x,
	input  logic signed [COORD_BITS-1:0] first_end_y,
	input  logic signed [COORD_BITS-1:0] second_start_x,
	input  logic signed [COORD_BITS-1:0] second_start_y,
	input  logic signed [COORD_BITS-1:0] second_end_x,
	input  logic signed [COORD_BITS-1:0] second_end_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic                         is_parallel,
	output logic signed [COORD_BITS-1:0] meet_x,
	output logic signed [COORD_BITS-1:0] meet_y
);

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int CW = 2 * DW + 1;
	localparam int NW = CW + CB;
	localparam int FS = segx_pkg::FRONT_STAGES;
	localparam int NS = FS + CB + segx_pkg::BACK_STAGES;
	localparam int SW = segx_pkg::FLAGS_BITS + 4 * CB;

	logic [NS-1:0] en;

	segx_ctrl #(.NS(NS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	segx_pkg::flags_t     f_fl;
	logic signed [CB-1:0] f_ptx, f_pty, f_s1x, f_s1y;
	logic [CW-1:0]        f_cm;
	logic [NW-1:0]        f_nx, f_ny;

	segx_front #(.CB(CB)) u_front (
		.clk            (clk),
		.en             (en[FS-1:0]),
		.first_start_x  (first_start_x),
		.first_start_y  (first_start_y),
		.first_end_x    (first_end_x),
		.first_end_y    (first_end_y),
		.second_start_x (second_start_x),
		.second_start_y (second_start_y),
		.second_end_x   (second_end_x),
		.second_end_y   (second_end_y),
		.flags          (f_fl),
		.ptx            (f_ptx),
		.pty            (f_pty),
		.s1x            (f_s1x),
		.s1y            (f_s1y),
		.cm             (f_cm),
		.nx             (f_nx),
		.ny             (f_ny)
	);

	logic [CB-1:0] d_qx, d_qy;
	logic [SW-1:0] d_side;

	segx_div #(.CB(CB), .CW(CW), .NW(NW), .SW(SW)) u_div (
		.clk      (clk),
		.en       (en[FS+CB-1:FS]),
		.cm_in    (f_cm),
		.nx_in    (f_nx),
		.ny_in    (f_ny),
		.side_in  ({f_fl, f_ptx, f_pty, f_s1x, f_s1y}),
		.qx       (d_qx),
		.qy       (d_qy),
		.side_out (d_side)
	);

	segx_pkg::flags_t     q_fl;
	logic signed [CB-1:0] q_ptx, q_pty, q_s1x, q_s1y;

	assign {q_fl, q_ptx, q_pty, q_s1x, q_s1y} = d_side;

	// apply quotient sign
	segx_pkg::flags_t     fl_sb1;
	logic signed [CB-1:0] ptx_sb1, pty_sb1, s1x_sb1, s1y_sb1;
	logic signed [CB:0]   qx_sb1, qy_sb1;

	always_ff @(posedge clk) begin
		if (en[NS-2]) begin
			fl_sb1 <= q_fl;
			ptx_sb1 <= q_ptx;
			pty_sb1 <= q_pty;
			s1x_sb1 <= q_s1x;
			s1y_sb1 <= q_s1y;
			qx_sb1 <= q_fl.neg_x ? -$signed({1'b0, d_qx}) : $signed({1'b0, d_qx});
			qy_sb1 <= q_fl.neg_y ? -$signed({1'b0, d_qy}) : $signed({1'b0, d_qy});
		end
	end

	function automatic logic signed [CB-1:0] sat(input logic signed [CB+1:0] v);
		logic signed [CB-1:0] r;
		if (v[CB+1:CB-1] == 3'b000 || v[CB+1:CB-1] == 3'b111) begin
			r = v[CB-1:0];
		end else if (v[CB+1]) begin
			r = {1'b1, {(CB-1){1'b0}}};
		end else begin
			r = {1'b0, {(CB-1){1'b1}}};
		end
		return r;
	endfunction

	logic signed [CB+1:0] sum_x, sum_y;
	logic signed [CB-1:0] res_x, res_y;

	always_comb begin
		sum_x = {{2{s1x_sb1[CB-1]}}, s1x_sb1} + {qx_sb1[CB], qx_sb1};
		sum_y = {{2{s1y_sb1[CB-1]}}, s1y_sb1} + {qy_sb1[CB], qy_sb1};
		if (!fl_sb1.hit) begin
			res_x = '0;
			res_y = '0;
		end else if (fl_sb1.use_pt) begin
			res_x = ptx_sb1;
			res_y = pty_sb1;
		end else begin
			res_x = sat(sum_x);
			res_y = sat(sum_y);
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			hit <= fl_sb1.hit;
			is_parallel <= fl_sb1.par;
			meet_x <= res_x;
			meet_y <= res_y;
		end
	end

endmodule
